/* hw/rtl/integer_calculator_alu_macros.svh */
// ----------------------------------------------------------------------------
// integer_calculator_alu_macros
// Assertion macros for the ALU checker, clocked on aclk, off during reset.
// ----------------------------------------------------------------------------
`ifndef INTEGER_CALCULATOR_ALU_MACROS_SVH
`define INTEGER_CALCULATOR_ALU_MACROS_SVH

// Implication checked on every clock edge outside reset
`define ICA_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication checked outside reset
`define ICA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/ica_pkg.sv */
// ----------------------------------------------------------------------------
// ica_pkg
// Types, opcodes and controller commands shared by the ALU modules.
// ----------------------------------------------------------------------------
package ica_pkg;

    localparam int DATA_WIDTH = 64;
    localparam int CNT_W      = $clog2(DATA_WIDTH + 1);

    localparam logic [3:0] OP_ADD = 4'd0;
    localparam logic [3:0] OP_SUB = 4'd1;
    localparam logic [3:0] OP_MUL = 4'd2;
    localparam logic [3:0] OP_OR  = 4'd3;
    localparam logic [3:0] OP_AND = 4'd4;
    localparam logic [3:0] OP_XOR = 4'd5;
    localparam logic [3:0] OP_DIV = 4'd6;
    localparam logic [3:0] OP_MOD = 4'd7;
    localparam logic [3:0] OP_GCD = 4'd8;
    localparam logic [3:0] OP_NOT = 4'd9;
    localparam logic [3:0] OP_SHR = 4'd10;
    localparam logic [3:0] OP_SHL = 4'd11;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_DIV0  = 2'd1;
    localparam logic [1:0] ST_SHIFT = 2'd2;

    typedef struct packed {
        logic [3:0]  opcode;
        logic signed [63:0] operand_a;
        logic signed [63:0] operand_b;
        logic        last;
    } ica_in_t;

    typedef struct packed {
        logic signed [63:0] value;
        logic [1:0]  status;
    } ica_out_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,     // partial-product multiply
        S_DIV,     // divider running for div/mod
        S_GCDDIV,  // divider running for one gcd step
        S_GCDCHK,  // gcd loop test
        S_OUT
    } ica_state_t;

    // controller -> datapath
    typedef struct packed {
        logic load;       // capture input beat
        logic simple;     // compute simple-op result from captured item
        logic mul_start;  // latch multiplicand, clear partial sum
        logic mul_step;   // add one partial product
        logic mul_fin;    // fold product into accumulator and result
        logic div_start;  // start divider on (a,b) at dispatch, else (x,y)
        logic div_step;   // one restoring step
        logic div_fin;    // write quotient/remainder to result
        logic gcd_swap;   // x<=y, y<=r
        logic gcd_fin;    // result <= x
    } ica_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic [3:0] opcode;
        logic       emit;     // simple op produces a result
        logic       div_zero; // divisor zero
        logic       mul_done;
        logic       div_done;
        logic       gcd_stop;
    } ica_stat_t;

endpackage

/* hw/rtl/ica_ctrl.sv */
// ----------------------------------------------------------------------------
// ica_ctrl
// Sequencer for the ALU: issues simple ops and drives the multiply and divider loops.
// ----------------------------------------------------------------------------
module ica_ctrl
    import ica_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      in_fire,
    input  logic      out_fire,
    input  ica_stat_t stat,
    output ica_cmd_t  cmd,
    output logic      in_ready,
    output logic      out_valid
);

    ica_state_t state_reg, state_next;
    logic       busy_reg, busy_next; // item captured, not yet dispatched

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            busy_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            busy_reg  <= busy_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        busy_next  = busy_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (busy_reg) begin
                    busy_next = 1'b0;
                    if (stat.opcode == OP_DIV || stat.opcode == OP_MOD) begin
                        state_next = stat.div_zero ? S_OUT : S_DIV;
                    end else if (stat.opcode == OP_GCD) begin
                        state_next = S_GCDCHK;
                    end else if (stat.opcode == OP_MUL) begin
                        state_next = S_MUL;
                    end else if (stat.emit) begin
                        state_next = S_OUT;
                    end
                end else if (in_fire) begin
                    busy_next = 1'b1;
                end
            end
            S_MUL:    if (stat.mul_done) state_next = stat.emit ? S_OUT : S_IDLE;
            S_DIV:    if (stat.div_done) state_next = S_OUT;
            S_GCDCHK: state_next = stat.gcd_stop ? S_OUT : S_GCDDIV;
            S_GCDDIV: if (stat.div_done) state_next = S_GCDCHK;
            S_OUT:    if (out_fire) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    always_comb begin
        cmd       = '0;
        in_ready  = (state_reg == S_IDLE) && !busy_reg;
        out_valid = (state_reg == S_OUT);
        cmd.load  = in_fire;
        unique case (state_reg)
            S_IDLE: begin
                if (busy_reg) begin
                    cmd.simple    = 1'b1;
                    cmd.mul_start = (stat.opcode == OP_MUL);
                    cmd.div_start = (stat.opcode == OP_DIV || stat.opcode == OP_MOD)
                                    && !stat.div_zero;
                end
            end
            S_MUL: begin
                cmd.mul_step = !stat.mul_done;
                cmd.mul_fin  = stat.mul_done;
            end
            S_DIV: begin
                cmd.div_step = !stat.div_done;
                cmd.div_fin  = stat.div_done;
            end
            S_GCDCHK: begin
                cmd.gcd_fin   = stat.gcd_stop;
                cmd.div_start = !stat.gcd_stop;
            end
            S_GCDDIV: begin
                cmd.div_step = !stat.div_done;
                cmd.gcd_swap = stat.div_done;
            end
            default: ;
        endcase
    end

endmodule

/* hw/rtl/ica_dpath.sv */
// ----------------------------------------------------------------------------
// ica_dpath
// Accumulator, simple ops, a partial-product multiplier, and a bit-serial restoring divider.
// ----------------------------------------------------------------------------
module ica_dpath
    import ica_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  ica_in_t   in_beat,
    input  ica_cmd_t  cmd,
    output ica_stat_t stat,
    output ica_out_t  result
);

    localparam int W = DATA_WIDTH;
    localparam int H = W / 2;

    logic [3:0]   op_reg;
    logic [W-1:0] a_reg, b_reg;
    logic         last_reg;
    logic [W-1:0] acc_reg, acc_next;
    logic         run_reg, run_next;
    logic [W-1:0] x_reg, y_reg;
    // multiplier: three half-width partial products, low W bits kept
    logic [W-1:0] mx_reg, mul_acc_reg;
    logic [1:0]   mcnt_reg;
    // divider
    logic [W-1:0] quo_reg, rem_reg, dvs_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic         qneg_reg, rneg_reg;
    ica_out_t     res_reg;

    logic [W-1:0] acc_base, fold_val;
    logic [H-1:0] mop_x, mop_y;
    logic [W-1:0] mprod;
    logic [W:0]   trial;
    logic [W-1:0] rem_sh, q_fix, r_fix, sx_a, sx_b;
    logic [W-1:0] shr_val, shl_val;
    logic         shift_bad;

    assign sx_a = a_reg;
    assign sx_b = b_reg;

    always_comb begin
        unique case (op_reg)
            OP_MUL:  acc_base = {{(W-1){1'b0}}, 1'b1};
            OP_AND:  acc_base = '1;
            default: acc_base = '0;
        endcase
        if (run_reg) acc_base = acc_reg;
    end

    always_comb begin
        unique case (mcnt_reg)
            2'd0: begin
                mop_x = mx_reg[H-1:0];
                mop_y = a_reg[H-1:0];
            end
            2'd1: begin
                mop_x = mx_reg[H-1:0];
                mop_y = a_reg[W-1:H];
            end
            default: begin
                mop_x = mx_reg[W-1:H];
                mop_y = a_reg[H-1:0];
            end
        endcase
    end

    assign mprod = {{H{1'b0}}, mop_x} * {{H{1'b0}}, mop_y};

    always_comb begin
        unique case (op_reg)
            OP_ADD:  fold_val = acc_base + a_reg;
            OP_SUB:  fold_val = acc_base - a_reg;
            OP_MUL:  fold_val = mul_acc_reg;
            OP_OR:   fold_val = acc_base | a_reg;
            OP_AND:  fold_val = acc_base & a_reg;
            default: fold_val = acc_base ^ a_reg;
        endcase
    end

    assign shift_bad = b_reg[W-1] || (b_reg > W'(W - 1));
    assign shr_val   = $signed(a_reg) >>> b_reg[$clog2(W)-1:0];
    assign shl_val   = a_reg << b_reg[$clog2(W)-1:0];

    assign rem_sh = {rem_reg[W-2:0], quo_reg[W-1]};
    assign trial  = {1'b0, rem_sh} - {1'b0, dvs_reg};
    assign q_fix  = qneg_reg ? -quo_reg : quo_reg;
    assign r_fix  = rneg_reg ? -rem_reg : rem_reg;

    always_comb begin
        acc_next = acc_reg;
        run_next = run_reg;
        // mul updates the accumulator only once the product is complete
        if ((cmd.simple && op_reg <= OP_XOR && op_reg != OP_MUL) || cmd.mul_fin) begin
            acc_next = fold_val;
            run_next = !last_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg <= '0;
            run_reg <= 1'b0;
            cnt_reg <= '0;
        end else begin
            acc_reg <= acc_next;
            run_reg <= run_next;
            if (cmd.div_start) cnt_reg <= CNT_W'(W);
            else if (cmd.div_step) cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg   <= in_beat.opcode;
            a_reg    <= in_beat.operand_a[W-1:0];
            b_reg    <= in_beat.operand_b[W-1:0];
            last_reg <= in_beat.last;
        end
        if (cmd.simple) begin
            x_reg <= sx_a;
            y_reg <= sx_b;
            res_reg.status <= ST_OK;
            unique case (op_reg)
                OP_ADD, OP_SUB, OP_MUL, OP_OR, OP_AND, OP_XOR:
                    res_reg.value <= 64'($signed(fold_val));
                OP_DIV, OP_MOD: begin
                    res_reg.value <= '0;
                    if (b_reg == '0) res_reg.status <= ST_DIV0;
                end
                OP_NOT: res_reg.value <= 64'($signed(~a_reg));
                OP_SHR, OP_SHL: begin
                    if (shift_bad) begin
                        res_reg.value  <= '0;
                        res_reg.status <= ST_SHIFT;
                    end else begin
                        res_reg.value <= 64'($signed(op_reg == OP_SHR ? shr_val
                                                                      : shl_val));
                    end
                end
                default: res_reg.value <= '0;
            endcase
        end
        if (cmd.mul_start) begin
            mx_reg      <= acc_base;
            mul_acc_reg <= '0;
            mcnt_reg    <= '0;
        end else if (cmd.mul_step) begin
            // cross products only reach the upper half
            mul_acc_reg <= mul_acc_reg + ((mcnt_reg == 2'd0) ? mprod
                                                             : {mprod[H-1:0], {H{1'b0}}});
            mcnt_reg    <= mcnt_reg + 2'd1;
        end
        if (cmd.mul_fin)
            res_reg.value <= 64'($signed(mul_acc_reg));
        if (cmd.div_start) begin
            // operands: captured item on dispatch, else current gcd pair
            logic [W-1:0] dn, dv;
            dn = cmd.simple ? a_reg : x_reg;
            dv = cmd.simple ? b_reg : y_reg;
            quo_reg  <= dn[W-1] ? -dn : dn;
            dvs_reg  <= dv[W-1] ? -dv : dv;
            rem_reg  <= '0;
            qneg_reg <= dn[W-1] ^ dv[W-1];
            rneg_reg <= dn[W-1];
        end else if (cmd.div_step) begin
            if (!trial[W]) begin
                rem_reg <= trial[W-1:0];
                quo_reg <= {quo_reg[W-2:0], 1'b1};
            end else begin
                rem_reg <= rem_sh;
                quo_reg <= {quo_reg[W-2:0], 1'b0};
            end
        end
        if (cmd.div_fin)
            res_reg.value <= 64'($signed(op_reg == OP_DIV ? q_fix : r_fix));
        if (cmd.gcd_swap) begin
            x_reg <= y_reg;
            y_reg <= r_fix;
        end
        if (cmd.gcd_fin) begin
            res_reg.value  <= 64'($signed(x_reg));
            res_reg.status <= ST_OK;
        end
    end

    assign stat.opcode   = op_reg;
    assign stat.emit     = (op_reg <= OP_XOR) ? last_reg : (op_reg <= OP_SHL);
    assign stat.div_zero = (b_reg == '0);
    assign stat.mul_done = (mcnt_reg == 2'd3);
    assign stat.div_done = (cnt_reg == '0);
    assign stat.gcd_stop = (x_reg == y_reg) || (y_reg == '0);
    assign result        = res_reg;

endmodule

/* hw/rtl/integer_calculator_alu.sv */
// ----------------------------------------------------------------------------
// integer_calculator_alu
// 64-bit signed accumulator ALU with folding runs, divide, gcd and shifts.
// ----------------------------------------------------------------------------
// Timing: an accepted beat is dispatched on the next cycle. Add, sub, or, and,
// xor, not and shifts register their result at dispatch and then present it.
// Mul builds the product from three half-width partial products, one per
// cycle, then folds it into the accumulator and answers. Div and mod run a
// one-bit-per-cycle restoring divider and answer once it is done. Gcd
// alternates a loop test with one divider run per Euclid step. One item is in flight at a
// time; s_ready rises the cycle after the result beat is taken, or right after
// the update for a folding item that emits nothing. Opcodes 12 to 15 are
// absorbed without a result.
module integer_calculator_alu
    import ica_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  ica_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output ica_out_t m_data
);

    ica_cmd_t  cmd;
    ica_stat_t stat;

    ica_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_fire   (s_valid && s_ready),
        .out_fire  (m_valid && m_ready),
        .stat      (stat),
        .cmd       (cmd),
        .in_ready  (s_ready),
        .out_valid (m_valid)
    );

    ica_dpath u_dpath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .in_beat (s_data),
        .cmd     (cmd),
        .stat    (stat),
        .result  (m_data)
    );

endmodule

/* hw/rtl/ica_checker.sv */
// ----------------------------------------------------------------------------
// ica_checker
// Port-level checks for the integer calculator ALU.
// ----------------------------------------------------------------------------
`include "integer_calculator_alu_macros.svh"

module ica_checker
    import ica_pkg::*;
(
    input logic     aclk,
    input logic     aresetn,
    input logic     s_valid,
    input logic     s_ready,
    input ica_in_t  s_data,
    input logic     m_valid,
    input logic     m_ready,
    input ica_out_t m_data
);

    `ICA_ASSERT_NEXT(a_in_hold, s_valid && !s_ready, s_valid && $stable(s_data), "in beat changed")
    `ICA_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_data), "out beat changed")
    `ICA_ASSERT_IMPL(a_one_flight, m_valid, !s_ready, "input taken while result pending")
    `ICA_ASSERT_IMPL(a_status_code, m_valid, m_data.status <= ST_SHIFT, "undefined status code")
    `ICA_ASSERT_IMPL(a_err_zero, m_valid && m_data.status != ST_OK, m_data.value == '0, "error value")

endmodule

bind integer_calculator_alu ica_checker u_ica_checker (.*);
